[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue and its cell chain.
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		CMD_PUSH_REAR  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_SHOW       = 3'd4
	} deq_cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SHIFT_R,
		OP_SHIFT_L,
		OP_ROTATE
	} deq_op_t;

	typedef enum logic {
		S_IDLE,
		S_SHOW
	} deq_state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
	} deq_req_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic               last;
	} deq_rsp_t;

	typedef struct packed {
		deq_op_t            op;
		logic [IW-1:0]      sel;
		logic signed [31:0] ins;
	} deq_ctrl_t;

endpackage

[rtl/deq_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the queue chain; it loads, holds or takes a neighbour's word.
module deq_cell (
	input  logic                      clk,
	input  deq_pkg::deq_ctrl_t        ctrl,
	input  logic [deq_pkg::IW-1:0]    idx,
	input  logic signed [31:0]        left,
	input  logic signed [31:0]        right,
	output logic signed [31:0]        q
);

	logic signed [31:0] data_q;
	logic signed [31:0] data_n;
	logic               hit;

	assign hit = (ctrl.sel == idx);
	assign q   = data_q;

	always_comb begin
		data_n = data_q;
		case (ctrl.op)
			deq_pkg::OP_LOAD: begin
				if (hit) data_n = ctrl.ins;
			end
			deq_pkg::OP_SHIFT_R: data_n = left;
			deq_pkg::OP_SHIFT_L: data_n = right;
			// The front word wraps round to the rear slot, everything else moves forward.
			deq_pkg::OP_ROTATE: data_n = hit ? ctrl.ins : right;
			default: data_n = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue built from a chain of storage cells, front held in cell 0.
// For push and pop the result beat is registered and appears the cycle after the request is taken.
// Show rotates the cells once round, one beat per stored element, one per cycle unless back-pressured.
// A new command is taken when the previous show has finished and the result register is free.
// Reset clears the fill count, the show sequencer and the result valid; cell contents are undefined.
module double_ended_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::deq_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output deq_pkg::deq_rsp_t  rsp
);

	localparam int DEPTH = deq_pkg::DEPTH;
	localparam int CW = deq_pkg::CW;
	localparam int IW = deq_pkg::IW;

	deq_pkg::deq_state_t state_q, state_n;
	logic [CW-1:0]       count_q, count_n;
	logic [IW-1:0]       show_q, show_n;
	deq_pkg::deq_rsp_t   rsp_q, rsp_n;
	logic                rsp_valid_q;
	logic                load_rsp;
	deq_pkg::deq_ctrl_t  ctrl;

	logic signed [31:0]  cell_q [DEPTH];
	logic signed [31:0]  rear_data;
	logic [IW-1:0]       rear_sel;
	logic                slot_free;
	logic                req_fire;
	logic                full;
	logic                empty;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == deq_pkg::S_IDLE) && slot_free;
	assign req_fire  = req_valid && req_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign rear_sel  = IW'(count_q - CW'(1));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = ctrl.ins;
		end else begin : g_mid
			assign left_w = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_inner
			assign right_w = cell_q[i+1];
		end
		deq_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.idx   (IW'(i)),
			.left  (left_w),
			.right (right_w),
			.q     (cell_q[i])
		);
	end

	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rear_sel == IW'(i)) rear_data = rear_data | cell_q[i];
		end
	end

	always_comb begin
		state_n     = state_q;
		count_n     = count_q;
		show_n      = show_q;
		load_rsp    = 1'b0;
		rsp_n       = rsp_q;
		ctrl.op     = deq_pkg::OP_HOLD;
		ctrl.sel    = IW'(count_q);
		ctrl.ins    = req.value;
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (req_fire) begin
					rsp_n.data   = '0;
					rsp_n.status = deq_pkg::ST_OK;
					rsp_n.last   = 1'b1;
					case (req.cmd)
						deq_pkg::CMD_PUSH_REAR: begin
							load_rsp = 1'b1;
							if (full) begin
								rsp_n.status = deq_pkg::ST_FULL;
							end else begin
								ctrl.op = deq_pkg::OP_LOAD;
								count_n = count_q + CW'(1);
							end
						end
						deq_pkg::CMD_PUSH_FRONT: begin
							load_rsp = 1'b1;
							if (full) begin
								rsp_n.status = deq_pkg::ST_FULL;
							end else begin
								ctrl.op = deq_pkg::OP_SHIFT_R;
								count_n = count_q + CW'(1);
							end
						end
						deq_pkg::CMD_POP_FRONT: begin
							load_rsp = 1'b1;
							if (empty) begin
								rsp_n.status = deq_pkg::ST_EMPTY;
							end else begin
								rsp_n.data = cell_q[0];
								ctrl.op    = deq_pkg::OP_SHIFT_L;
								count_n    = count_q - CW'(1);
							end
						end
						deq_pkg::CMD_POP_REAR: begin
							load_rsp = 1'b1;
							if (empty) begin
								rsp_n.status = deq_pkg::ST_EMPTY;
							end else begin
								rsp_n.data = rear_data;
								count_n    = count_q - CW'(1);
							end
						end
						deq_pkg::CMD_SHOW: begin
							load_rsp = 1'b1;
							if (empty) begin
								rsp_n.status = deq_pkg::ST_EMPTY;
							end else begin
								rsp_n.data = cell_q[0];
								rsp_n.last = (count_q == CW'(1));
								ctrl.op    = deq_pkg::OP_ROTATE;
								ctrl.sel   = rear_sel;
								ctrl.ins   = cell_q[0];
								show_n     = IW'(1);
								if (count_q != CW'(1)) state_n = deq_pkg::S_SHOW;
							end
						end
						default: load_rsp = 1'b0;
					endcase
				end
			end
			deq_pkg::S_SHOW: begin
				if (slot_free) begin
					load_rsp     = 1'b1;
					rsp_n.data   = cell_q[0];
					rsp_n.status = deq_pkg::ST_OK;
					rsp_n.last   = ((CW'(show_q) + CW'(1)) == count_q);
					ctrl.op      = deq_pkg::OP_ROTATE;
					ctrl.sel     = rear_sel;
					ctrl.ins     = cell_q[0];
					show_n       = show_q + IW'(1);
					if (rsp_n.last) state_n = deq_pkg::S_IDLE;
				end
			end
			default: state_n = deq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::S_IDLE;
			count_q     <= '0;
			show_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			show_q  <= show_n;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) rsp_q <= rsp_n;
	end

endmodule

[test/tb_double_ended_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue, with a built-in ring predictor.
module tb_double_ended_queue;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int ITEM_TARGET    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 3 * deq_pkg::DEPTH + 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int HOLD_AT_ITEM   = 100;
	localparam int CALM_FIRST     = 200;
	localparam int CALM_LAST      = 280;
	localparam int IDLE_PERCENT   = 33;

	// Commands the block must ignore without producing a beat.
	localparam logic [2:0] CMD_RSVD_A = 3'd5;
	localparam logic [2:0] CMD_RSVD_B = 3'd6;
	localparam logic [2:0] CMD_RSVD_C = 3'd7;

	localparam logic signed [31:0] VAL_MAX  = 32'sh7fffffff;
	localparam logic signed [31:0] VAL_MIN  = 32'sh80000000;
	localparam logic signed [31:0] VAL_ZERO = 32'sh00000000;
	localparam logic signed [31:0] VAL_ONES = 32'shffffffff;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	deq_pkg::deq_req_t req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	deq_pkg::deq_rsp_t rsp;

	double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Predictor state: front index and occupancy of a ring of DEPTH entries.
	logic signed [31:0] ring_copy [deq_pkg::DEPTH];
	int                 front_pos = 0;
	int                 stored_cnt = 0;

	deq_pkg::deq_req_t pending_reqs [$];
	deq_pkg::deq_rsp_t awaited_beats [$];

	int  req_count = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  req_fired = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;

	// Generator's view of occupancy, used only to shape the stimulus.
	int  plan_fill = 0;
	int  plan_items = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic bit calm_window();
		return (req_count >= CALM_FIRST) && (req_count < CALM_LAST);
	endfunction

	task automatic await_beat(input logic signed [31:0] d, input logic [1:0] st, input logic lst);
		deq_pkg::deq_rsp_t b;
		b.data   = d;
		b.status = st;
		b.last   = lst;
		awaited_beats.push_back(b);
	endtask

	task automatic predict_deque(input deq_pkg::deq_req_t r);
		int i;
		case (r.cmd)
			deq_pkg::CMD_PUSH_REAR: begin
				if (stored_cnt >= deq_pkg::DEPTH) begin
					await_beat(VAL_ZERO, deq_pkg::ST_FULL, 1'b1);
				end else begin
					ring_copy[(front_pos + stored_cnt) % deq_pkg::DEPTH] = r.value;
					stored_cnt++;
					await_beat(VAL_ZERO, deq_pkg::ST_OK, 1'b1);
				end
			end
			deq_pkg::CMD_PUSH_FRONT: begin
				if (stored_cnt >= deq_pkg::DEPTH) begin
					await_beat(VAL_ZERO, deq_pkg::ST_FULL, 1'b1);
				end else begin
					front_pos = (front_pos + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
					ring_copy[front_pos] = r.value;
					stored_cnt++;
					await_beat(VAL_ZERO, deq_pkg::ST_OK, 1'b1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (stored_cnt == 0) begin
					await_beat(VAL_ZERO, deq_pkg::ST_EMPTY, 1'b1);
				end else begin
					await_beat(ring_copy[front_pos], deq_pkg::ST_OK, 1'b1);
					front_pos = (front_pos + 1) % deq_pkg::DEPTH;
					stored_cnt--;
				end
			end
			deq_pkg::CMD_POP_REAR: begin
				if (stored_cnt == 0) begin
					await_beat(VAL_ZERO, deq_pkg::ST_EMPTY, 1'b1);
				end else begin
					await_beat(ring_copy[(front_pos + stored_cnt - 1) % deq_pkg::DEPTH],
						deq_pkg::ST_OK, 1'b1);
					stored_cnt--;
				end
			end
			deq_pkg::CMD_SHOW: begin
				if (stored_cnt == 0) begin
					await_beat(VAL_ZERO, deq_pkg::ST_EMPTY, 1'b1);
				end else begin
					for (i = 0; i < stored_cnt; i++)
						await_beat(ring_copy[(front_pos + i) % deq_pkg::DEPTH],
							deq_pkg::ST_OK, i == stored_cnt - 1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic add_item(input logic [2:0] c, input logic signed [31:0] v);
		deq_pkg::deq_req_t r;
		r.cmd   = c;
		r.value = v;
		pending_reqs.push_back(r);
		case (c)
			deq_pkg::CMD_PUSH_REAR, deq_pkg::CMD_PUSH_FRONT:
				if (plan_fill < deq_pkg::DEPTH) plan_fill++;
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR:
				if (plan_fill > 0) plan_fill--;
			default: ;
		endcase
		if (c <= deq_pkg::CMD_SHOW)
			plan_items++;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return VAL_ZERO;
			3: return VAL_ONES;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_REAR;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_REAR;
	endfunction

	// Request side: a new beat is offered only once the previous one has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fired) begin
			req_fired = 1'b0;
			if (pending_reqs.size() != 0 &&
			    (calm_window() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: random back-pressure, plus one long hold that stalls the block.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!hold_done && req_count >= HOLD_AT_ITEM) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_deque(req);
				req_count++;
				req_fired = 1'b1;
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_beats.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat data=%0d status=%0d last=%0b",
						$time, rsp.data, rsp.status, rsp.last);
				end else begin
					deq_pkg::deq_rsp_t want;
					want = awaited_beats.pop_front();
					if (rsp.data !== want.data || rsp.status !== want.status ||
					    rsp.last !== want.last) begin
						mismatches++;
						$display("%0t: mismatch expected data=%0d status=%0d last=%0b, got data=%0d status=%0d last=%0b",
							$time, want.data, want.status, want.last,
							rsp.data, rsp.status, rsp.last);
					end
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int k;

		// Directed: empty-deque cases, ignored commands, extremes and single-element pops.
		add_item(deq_pkg::CMD_POP_FRONT, VAL_MAX);
		add_item(deq_pkg::CMD_POP_REAR, VAL_MIN);
		add_item(deq_pkg::CMD_SHOW, VAL_ONES);
		add_item(CMD_RSVD_A, VAL_MAX);
		add_item(CMD_RSVD_B, VAL_ONES);
		add_item(CMD_RSVD_C, VAL_MIN);
		add_item(deq_pkg::CMD_PUSH_REAR, VAL_MAX);
		add_item(deq_pkg::CMD_POP_REAR, VAL_ZERO);
		add_item(deq_pkg::CMD_PUSH_FRONT, VAL_MIN);
		add_item(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
		add_item(deq_pkg::CMD_PUSH_REAR, 32'sd1);
		add_item(deq_pkg::CMD_PUSH_FRONT, VAL_ONES);
		add_item(deq_pkg::CMD_PUSH_REAR, VAL_MAX);
		add_item(deq_pkg::CMD_PUSH_FRONT, VAL_MIN);
		add_item(deq_pkg::CMD_SHOW, VAL_ZERO);
		add_item(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
		add_item(deq_pkg::CMD_POP_REAR, VAL_ZERO);
		add_item(deq_pkg::CMD_SHOW, VAL_ZERO);
		add_item(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
		add_item(deq_pkg::CMD_POP_REAR, VAL_ZERO);
		add_item(deq_pkg::CMD_POP_FRONT, VAL_ZERO);

		// Random: fill and drain runs that reach both bounds, mixed with free traffic.
		while (plan_items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					while (plan_fill < deq_pkg::DEPTH)
						add_item(pick_push(), pick_value());
					add_item(deq_pkg::CMD_PUSH_REAR, pick_value());
					add_item(deq_pkg::CMD_PUSH_FRONT, pick_value());
					add_item(deq_pkg::CMD_SHOW, pick_value());
				end
				2, 3: begin
					while (plan_fill > 0)
						add_item(pick_pop(), pick_value());
					add_item(deq_pkg::CMD_POP_FRONT, pick_value());
					add_item(deq_pkg::CMD_POP_REAR, pick_value());
					add_item(deq_pkg::CMD_SHOW, pick_value());
				end
				default: begin
					n = $urandom_range(4, 12);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 19))
							0, 1:   add_item(deq_pkg::CMD_SHOW, pick_value());
							2:      add_item(3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C)),
									pick_value());
							3, 4, 5, 6, 7, 8, 9, 10, 11:
								add_item(pick_push(), pick_value());
							default: add_item(pick_pop(), pick_value());
						endcase
					end
				end
			endcase
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_beats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
